// ----- src/oaht_pkg.sv -----
// Shared types and constants for the open-addressing hash table unit.
package oaht_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_SLOT  = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_code_t;

    localparam logic [1:0] TAG_EMPTY   = 2'd0;
    localparam logic [1:0] TAG_LIVE    = 2'd1;
    localparam logic [1:0] TAG_DELETED = 2'd2;

    localparam logic [31:0] GOLDEN_FRAC = 32'h9E3779B9;

    localparam logic [0:0] REG_SIZE_LOG2 = 1'b0;
    localparam logic [0:0] REG_HASH_MODE = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic signed [31:0] entry_key;
        logic [31:0] entry_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  slot_index;
        logic [31:0] found_value;
        logic [7:0]  count;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture item, start digit sum
        logic digit;      // one decimal digit step
        logic mul;        // multiplicative hash step
        logic home;       // set probe slot to home
        logic rd;         // issue slot read
        logic step;       // advance to next probe slot
        logic wr_ins;     // write live entry
        logic wr_del;     // mark deleted
        logic res_ok;     // result done at current slot
        logic res_fail;   // result failure
        logic emit;       // move result into the output register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] opcode;
        logic       digits_done;
        logic       full;
        logic       empty_tbl;
        logic       tag_empty;
        logic       tag_live;
        logic       key_match;
        logic       last_probe;
    } sts_t;

endpackage

// ----- src/oaht_datapath.sv -----
// Datapath of the hash table: key digit sum, home slot, probe walk, slot storage.
module oaht_datapath #(
    parameter int MAX_SLOTS     = 128,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    input  oaht_pkg::in_item_t in_item,
    input  oaht_pkg::cmd_t     cmd,
    output oaht_pkg::sts_t     sts,
    output oaht_pkg::out_item_t res
);
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = AW + 1;

    logic [1:0] tag_mem [MAX_SLOTS];
    logic [31:0] key_mem [MAX_SLOTS];
    logic [PAYLOAD_WIDTH-1:0] pay_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] tag_valid_reg;

    logic [2:0]  size_log2_reg;
    logic        hash_mode_reg;
    logic [1:0]  op_reg;
    logic [31:0] key_reg;
    logic [PAYLOAD_WIDTH-1:0] val_reg;
    logic [31:0] mag_reg, mag_next;
    logic [8:0]  sum_reg;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] home_mul_reg;
    logic [CW-1:0] probe_reg;
    logic [CW-1:0] live_reg;
    logic [1:0]  rd_tag_reg;
    logic [31:0] rd_key_reg;
    logic [PAYLOAD_WIDTH-1:0] rd_pay_reg;
    oaht_pkg::out_item_t res_reg;
    oaht_pkg::out_item_t out_reg;

    logic [2:0]  lg;
    logic [CW-1:0] size;
    logic [AW-1:0] mask;
    logic [3:0]  digit;
    logic [AW-1:0] h_mod;
    logic [31:0] frac;
    logic [AW-1:0] step_sz;
    logic [CW+2:0] ip;

    always_comb begin
        lg = size_log2_reg;
        if (lg < 3'd4) lg = 3'd4;
        if (lg > 3'd7) lg = 3'd7;
        if (int'(lg) > AW) lg = 3'(AW);
        size = CW'(1) << lg;
        mask = AW'(size - CW'(1));
        mag_next = 32'((64'(mag_reg) * 64'h0000_0000_CCCC_CCCD) >> 35);
        digit = 4'(mag_reg - mag_next * 32'd10);
        h_mod = AW'(sum_reg) & mask;
        frac = 32'(h_mod) * oaht_pkg::GOLDEN_FRAC;
        ip = (CW+3)'(probe_reg) + CW'(1);
        step_sz = AW'(ip * 3'd5 + ip * ip * 2'd3) & mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg <= 3'd4;
            hash_mode_reg <= 1'b0;
            live_reg      <= '0;
            tag_valid_reg <= '0;
        end else begin
            if (cfg_we && cfg_index == oaht_pkg::REG_SIZE_LOG2) size_log2_reg <= cfg_data;
            if (cfg_we && cfg_index == oaht_pkg::REG_HASH_MODE) hash_mode_reg <= cfg_data[0];
            if (cmd.wr_ins) begin
                live_reg <= live_reg + CW'(1);
                tag_valid_reg[slot_reg] <= 1'b1;
            end
            if (cmd.wr_del) live_reg <= live_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_ins || cmd.wr_del)
            tag_mem[slot_reg] <= cmd.wr_ins ? oaht_pkg::TAG_LIVE : oaht_pkg::TAG_DELETED;
        if (cmd.wr_ins) begin
            key_mem[slot_reg] <= key_reg;
            pay_mem[slot_reg] <= val_reg;
        end
        if (cmd.rd) begin
            rd_tag_reg <= tag_valid_reg[slot_reg] ? tag_mem[slot_reg] : oaht_pkg::TAG_EMPTY;
            rd_key_reg <= key_mem[slot_reg];
            rd_pay_reg <= pay_mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_item.opcode;
            key_reg <= in_item.entry_key;
            val_reg <= PAYLOAD_WIDTH'(in_item.entry_value);
            mag_reg <= in_item.entry_key[31] ? (~in_item.entry_key) + 32'd1 : in_item.entry_key;
            sum_reg <= in_item.entry_key[31] ? 9'd45 : 9'd0;
        end
        if (cmd.digit) begin
            mag_reg <= mag_next;
            sum_reg <= sum_reg + 9'd48 + 9'(digit);
        end
        if (cmd.mul) home_mul_reg <= AW'(frac >> (6'd32 - 6'(lg)));
        if (cmd.home) begin
            slot_reg  <= hash_mode_reg ? home_mul_reg : h_mod;
            probe_reg <= '0;
        end
        if (cmd.step) begin
            slot_reg  <= (slot_reg + step_sz) & mask;
            probe_reg <= probe_reg + CW'(1);
        end
        if (cmd.res_ok) begin
            res_reg.status      <= oaht_pkg::ST_DONE;
            res_reg.slot_index  <= 7'(slot_reg);
            res_reg.found_value <= (op_reg == oaht_pkg::OP_INSERT) ? 32'd0 : 32'(rd_pay_reg);
            res_reg.count       <= (op_reg == oaht_pkg::OP_INSERT) ? 8'(live_reg + CW'(1)) :
                                   (op_reg == oaht_pkg::OP_DELETE) ? 8'(live_reg - CW'(1)) :
                                   8'(live_reg);
        end
        if (cmd.res_fail) begin
            res_reg.status      <= (op_reg == oaht_pkg::OP_INSERT) ? oaht_pkg::ST_NO_SLOT
                                                                  : oaht_pkg::ST_NOTFOUND;
            res_reg.slot_index  <= '0;
            res_reg.found_value <= '0;
            res_reg.count       <= 8'(live_reg);
        end
        if (cmd.emit) out_reg <= res_reg;
    end

    assign sts.opcode      = op_reg;
    assign sts.digits_done = (mag_next == 32'd0);
    assign sts.full        = (live_reg >= size);
    assign sts.empty_tbl   = (live_reg == '0);
    assign sts.tag_empty   = (rd_tag_reg == oaht_pkg::TAG_EMPTY);
    assign sts.tag_live    = (rd_tag_reg == oaht_pkg::TAG_LIVE);
    assign sts.key_match   = (rd_key_reg == key_reg);
    assign sts.last_probe  = (probe_reg == size - CW'(1));
    assign res = out_reg;
endmodule

// ----- src/oaht_ctrl.sv -----
// Controller of the hash table: sequences hashing, probing and result hand-off.
module oaht_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  oaht_pkg::sts_t sts,
    output oaht_pkg::cmd_t cmd
);
    typedef enum logic [2:0] {
        IDLE, DIGITS, MUL, HOME, READ, CHECK, RESULT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd = '0;
        cmd.load  = (state_reg == IDLE) && s_valid;
        cmd.digit = (state_reg == DIGITS);
        cmd.mul   = (state_reg == MUL);
        cmd.home  = (state_reg == HOME);
        cmd.rd    = (state_reg == READ);
        cmd.emit  = (state_reg == RESULT) && (!m_valid_reg || m_ready);
        if (state_reg == HOME) begin
            if (sts.opcode == oaht_pkg::OP_INSERT && sts.full) cmd.res_fail = 1'b1;
            if (sts.opcode != oaht_pkg::OP_INSERT && sts.empty_tbl) cmd.res_fail = 1'b1;
            if (sts.opcode != oaht_pkg::OP_INSERT && sts.opcode != oaht_pkg::OP_SEARCH &&
                sts.opcode != oaht_pkg::OP_DELETE) cmd.res_fail = 1'b1;
            if (cmd.res_fail) cmd.home = 1'b0;
        end
        if (state_reg == CHECK) begin
            if (sts.opcode == oaht_pkg::OP_INSERT) begin
                if (!sts.tag_live) begin
                    cmd.wr_ins = 1'b1;
                    cmd.res_ok = 1'b1;
                end else if (sts.last_probe) cmd.res_fail = 1'b1;
                else cmd.step = 1'b1;
            end else begin
                if (sts.tag_empty) cmd.res_fail = 1'b1;
                else if (sts.tag_live && sts.key_match) begin
                    cmd.res_ok = 1'b1;
                    cmd.wr_del = (sts.opcode == oaht_pkg::OP_DELETE);
                end else if (sts.last_probe) cmd.res_fail = 1'b1;
                else cmd.step = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                IDLE:    if (s_valid) state_reg <= DIGITS;
                DIGITS:  if (sts.digits_done) state_reg <= MUL;
                MUL:     state_reg <= HOME;
                HOME:    state_reg <= cmd.res_fail ? RESULT : READ;
                READ:    state_reg <= CHECK;
                CHECK:   state_reg <= (cmd.res_ok || cmd.res_fail) ? RESULT : READ;
                RESULT:  if (cmd.emit) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
endmodule

// ----- src/open_addressing_hash_table_unit.sv -----
// Top level of the open-addressing hash table unit.
//   channel   | ports                          | direction
//   request   | s_valid s_ready s_item         | in
//   result    | m_valid m_ready m_item         | out
//   config    | cfg_we cfg_index cfg_data      | in
// An item goes through digit sum, hash, home slot, probe walk and result in that order.
// The probe walk reads one slot per probe from the slot storage.
// Reset empties all slots, zeroes the live count and loads default config.
// A finished item waits in the output register while the next one is accepted.
module open_addressing_hash_table_unit #(
    parameter int MAX_SLOTS     = 128,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  oaht_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output oaht_pkg::out_item_t m_item,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [2:0]          cfg_data
);
    oaht_pkg::cmd_t cmd;
    oaht_pkg::sts_t sts;

    oaht_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .cmd
    );

    oaht_datapath #(.MAX_SLOTS(MAX_SLOTS), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .in_item(s_item), .cmd, .sts, .res(m_item)
    );
endmodule
